### sv/assert_macros.svh
// Assertion macros shared by the IMU filter RTL.
// Depends on nothing; compile with ASSERT_OFF defined to drop all checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    `ASSERT_CLK(lbl, clk, rstn, !(cond), msg)

`else

`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

### sv/imu_ma_pkg.sv
// Constants and types for the IMU moving-average filter and yaw integrator.
// Depends on nothing; used by imu_moving_average_and_yaw_integrator.
`default_nettype none

package imu_ma_pkg;

    // Sample and window geometry
    localparam int DATA_W   = 16;
    localparam int AXES     = 3;
    localparam int WINDOW   = 20;
    localparam int WIN_LOG  = $clog2(WINDOW);
    localparam int SLOT_W   = WIN_LOG;
    localparam int SAMPLE_W = AXES * DATA_W;

    // Running sum holds up to WINDOW * 2^15 in magnitude
    localparam int SUM_W    = DATA_W + WIN_LOG;

    // Exact divide by WINDOW: floor(mag * RECIP / 2^SHIFT) for every mag < 2^SUM_W
    localparam int SHIFT    = SUM_W + WIN_LOG;
    localparam int RECIP_W  = SUM_W + 1;
    localparam int PROD_W   = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

    // Yaw accumulator, LSB = 1/65536 degree
    localparam int YAW_W = 40;
    localparam logic signed [YAW_W-1:0] YAW_MAX = {1'b0, {(YAW_W-1){1'b1}}};
    localparam logic signed [YAW_W-1:0] YAW_MIN = {1'b1, {(YAW_W-1){1'b0}}};

    // Stream widths
    localparam int S_TDATA_W = 4 * DATA_W;
    localparam int M_TDATA_W = AXES * DATA_W + YAW_W;

    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

    // One accelerometer triple, X in the lowest lane
    typedef logic [AXES-1:0][DATA_W-1:0] accel_vec_t;

endpackage

`default_nettype wire

### sv/imu_moving_average_and_yaw_integrator.sv
// IMU moving-average filter and yaw integrator, top level.
// Depends on imu_ma_pkg and assert_macros.svh.
//
// Takes one raw IMU request per cycle while s_tready is high (three
// accelerometer axes and gyro Z) and returns the mean of the last WINDOW
// samples of each axis (truncated toward zero; windows start filled with
// zeros) and the saturating 40-bit integral of gyro Z in 1/65536 degree.
// Sustained rate is one item per clock while m_tready stays high: the
// sample windows live in one memory with a registered read, and running
// sums are updated by adding the new sample and subtracting the one read
// back from the same slot. A request passes the memory read, the sum
// update, the reciprocal multiply that divides by WINDOW and the output
// register. Per-entry valid bits make the windows read as zero after reset,
// so there is no clearing pass. Each stage holds its request when the next
// is full, so until all stages fill, input is taken while a finished result waits on m_tready.
`default_nettype none
`include "assert_macros.svh"

module imu_moving_average_and_yaw_integrator (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // accel_x [15:0], accel_y [31:16], accel_z [47:32], gyro_rate_z [63:48]
    input  logic [imu_ma_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // avg_x [15:0], avg_y [31:16], avg_z [47:32], yaw_angle [87:48]
    output logic [imu_ma_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int DATA_W = imu_ma_pkg::DATA_W;
    localparam int AXES   = imu_ma_pkg::AXES;
    localparam int WINDOW = imu_ma_pkg::WINDOW;
    localparam int SLOT_W = imu_ma_pkg::SLOT_W;
    localparam int SUM_W  = imu_ma_pkg::SUM_W;
    localparam int PROD_W = imu_ma_pkg::PROD_W;
    localparam int YAW_W  = imu_ma_pkg::YAW_W;
    localparam int SHIFT  = imu_ma_pkg::SHIFT;

    // Window memory and slot pointer
    imu_ma_pkg::accel_vec_t win_mem [WINDOW];
    logic [WINDOW-1:0]      win_valid_reg;
    logic [SLOT_W-1:0]      slot_reg, slot_next;

    // Stage 1: request plus old sample read from its slot
    logic                       s1_valid_reg;
    imu_ma_pkg::accel_vec_t     s1_accel_reg;
    logic signed [DATA_W-1:0]   s1_gyro_reg;
    logic [SLOT_W-1:0]          s1_slot_reg;
    imu_ma_pkg::accel_vec_t     rd_data_reg;
    logic                       rd_valid_reg;

    // Running state
    logic signed [SUM_W-1:0]    sum_reg  [AXES];
    logic signed [SUM_W-1:0]    sum_next [AXES];
    logic signed [YAW_W-1:0]    yaw_reg, yaw_next;
    logic signed [YAW_W:0]      yaw_wide;

    // Stage 2: sums are current in sum_reg
    logic                       s2_valid_reg;
    logic signed [YAW_W-1:0]    s2_yaw_reg;
    logic [SUM_W-1:0]           mag   [AXES];
    logic [PROD_W-1:0]          prod  [AXES];

    // Stage 3: reciprocal products
    logic                       s3_valid_reg;
    logic [PROD_W-1:0]          s3_prod_reg [AXES];
    logic [AXES-1:0]            s3_neg_reg;
    logic signed [YAW_W-1:0]    s3_yaw_reg;
    logic [DATA_W:0]            quot [AXES];
    logic [DATA_W:0]            avg_full [AXES];

    // Output register
    logic                          m_tvalid_reg;
    logic [imu_ma_pkg::M_TDATA_W-1:0] m_tdata_reg;

    // Stage occupancy: a stage loads when empty or when it moves on
    logic out_free, s3_free, s2_free, s1_free, accept;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s3_free  = !s3_valid_reg || out_free;
    assign s2_free  = !s2_valid_reg || s3_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign accept   = s_tvalid && s1_free;

    assign s_tready = s1_free;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Slot pointer wraps at WINDOW
    always_comb begin
        slot_next = (slot_reg == imu_ma_pkg::SLOT_LAST) ? '0 : slot_reg + 1'b1;
    end

    // Window memory: write back at stage 1 exit, read at acceptance
    always_ff @(posedge aclk) begin
        if (s1_valid_reg && s2_free) begin
            win_mem[s1_slot_reg] <= s1_accel_reg;
        end
        if (s1_free) begin
            rd_data_reg <= win_mem[slot_reg];
        end
    end

    // Valid bits and stage 1 control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_valid_reg <= '0;
            slot_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            rd_valid_reg  <= 1'b0;
        end else begin
            if (s1_valid_reg && s2_free) begin
                win_valid_reg[s1_slot_reg] <= 1'b1;
            end
            if (s1_free) begin
                s1_valid_reg <= s_tvalid;
                rd_valid_reg <= win_valid_reg[slot_reg];
            end
            if (accept) begin
                slot_reg <= slot_next;
            end
        end
    end

    // Stage 1 payload
    always_ff @(posedge aclk) begin
        if (s1_free) begin
            s1_accel_reg <= s_tdata[imu_ma_pkg::SAMPLE_W-1:0];
            s1_gyro_reg  <= s_tdata[imu_ma_pkg::S_TDATA_W-1 -: DATA_W];
            s1_slot_reg  <= slot_reg;
        end
    end

    // Running sums: add the new sample, drop the one it replaces
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            sum_next[a] = sum_reg[a]
                        + SUM_W'($signed(s1_accel_reg[a]))
                        - SUM_W'($signed(rd_valid_reg ? rd_data_reg[a] : '0));
        end
    end

    // Saturating yaw accumulation
    always_comb begin
        yaw_wide = {yaw_reg[YAW_W-1], yaw_reg} + (YAW_W+1)'(s1_gyro_reg);
        if (yaw_wide[YAW_W] != yaw_wide[YAW_W-1]) begin
            yaw_next = yaw_wide[YAW_W] ? imu_ma_pkg::YAW_MIN : imu_ma_pkg::YAW_MAX;
        end else begin
            yaw_next = yaw_wide[YAW_W-1:0];
        end
    end

    // Stage 1 to 2: state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < AXES; a++) begin
                sum_reg[a] <= '0;
            end
            yaw_reg      <= '0;
            s2_valid_reg <= 1'b0;
        end else if (s2_free) begin
            s2_valid_reg <= s1_valid_reg;
            if (s1_valid_reg) begin
                for (int a = 0; a < AXES; a++) begin
                    sum_reg[a] <= sum_next[a];
                end
                yaw_reg <= yaw_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_free) begin
            s2_yaw_reg <= yaw_next;
        end
    end

    // Stage 2: magnitude times reciprocal of WINDOW
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            mag[a]  = sum_reg[a][SUM_W-1] ? SUM_W'(-sum_reg[a]) : SUM_W'(sum_reg[a]);
            prod[a] = PROD_W'(mag[a]) * PROD_W'(imu_ma_pkg::RECIP);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (s3_free) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_free) begin
            for (int a = 0; a < AXES; a++) begin
                s3_prod_reg[a] <= prod[a];
                s3_neg_reg[a]  <= sum_reg[a][SUM_W-1];
            end
            s3_yaw_reg <= s2_yaw_reg;
        end
    end

    // Stage 3: quotient, sign restored (truncation toward zero)
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            quot[a]     = s3_prod_reg[a][SHIFT +: DATA_W+1];
            avg_full[a] = s3_neg_reg[a] ? (~quot[a] + 1'b1) : quot[a];
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_free) begin
            m_tvalid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            m_tdata_reg <= {s3_yaw_reg,
                            avg_full[2][DATA_W-1:0],
                            avg_full[1][DATA_W-1:0],
                            avg_full[0][DATA_W-1:0]};
        end
    end

    // Write-back and read of one cycle never hit the same slot
    `ASSERT_NEVER(a_slot_hazard, aclk, aresetn, s1_valid_reg && s2_free && s1_free && (s1_slot_reg == slot_reg), "write-back and read share a window slot")

    // Window valid bits are never cleared outside reset
    `ASSERT_CLK(a_valid_grow, aclk, aresetn, $past(aresetn) |-> (($past(win_valid_reg) & ~win_valid_reg) == '0), "window valid bit cleared")

    // Running sum of axis X moves only when a request leaves stage 1
    `ASSERT_CLK(a_sum_hold, aclk, aresetn, ($past(aresetn) && !$past(s1_valid_reg && s2_free)) |-> $stable(sum_reg[0]), "running sum changed without a request")

    // Input stalls only when every stage is full
    `ASSERT_CLK(a_full_stall, aclk, aresetn, !s_tready |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg && m_tvalid_reg), "input stalled with a free stage")

endmodule

`default_nettype wire
